// ===== sv/bswc_pkg.sv =====
package bswc_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned DATA_WIDTH  = 32;

  localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned ERR_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

endpackage

// ===== sv/bswc_ram.sv =====
module bswc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/bounded_stack_with_count_core.sv =====
// LIFO stack with an entry count search.
// Input channel: in_valid_i / in_stall_o carry operation_i (push, pop, count)
// and value_i (data to push or key to count). Output channel: out_valid_o /
// out_stall_i carry one result per input transfer: top entry with its valid
// flag, depth, empty flag, match count and error code.
// Entries live in a single-port-write, registered-read RAM. The top entry is
// also held in a register, so push needs no read; pop reads the new top from
// the RAM, and a count request reads the stored entries one per cycle.
// After an input transfer, push, no-op and underflow go straight to S_OUT; pop
//   passes S_POP to load the new top (not when it empties the stack), count passes
//   S_SCAN over the stored entries (not on an empty stack); S_OUT loads the result.
// The next item is taken the cycle after its result enters the output register, as
// input stalls until then; the count scan over the RAM's one read port is longest.
// A push onto a full stack is dropped and flagged as overflow; a pop from an
// empty stack is flagged as underflow. Both leave the stack unchanged.
// Reset empties the stack and the output register; RAM contents are not
// cleared, since only entries below the depth are ever read.
// While the receiver stalls, the result holds on the outputs; one further
// item can be accepted and worked on, and its result waits until the
// output register frees up.
module bounded_stack_with_count_core
  import bswc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VALUE_W-1:0] top_value_o,
  output logic               top_valid_o,
  output logic [LEVEL_W-1:0] depth_now_o,
  output logic               is_empty_o,
  output logic [LEVEL_W-1:0] match_count_o,
  output logic [ERR_W-1:0]   error_code_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic [CNT_W-1:0]      match_q, match_d;
  logic [ERR_W-1:0]      err_q, err_d;
  logic [DATA_WIDTH-1:0] top_q, top_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]    top_value_q, top_value_d;
  logic                  top_valid_q, top_valid_d;
  logic [LEVEL_W-1:0]    depth_now_q, depth_now_d;
  logic                  is_empty_q, is_empty_d;
  logic [LEVEL_W-1:0]    match_count_q, match_count_d;
  logic [ERR_W-1:0]      error_code_q, error_code_d;

  logic                  in_xfer;
  logic                  out_free;
  logic [DATA_WIDTH-1:0] in_data;
  logic [CNT_W-1:0]      pop_ptr;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_data    = DATA_WIDTH'(value_i);
  assign pop_ptr    = fill_q - CNT_W'(2);
  assign ram_waddr  = fill_q[ADDR_W-1:0];

  bswc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    scan_d    = scan_q;
    match_d   = match_q;
    err_d     = err_q;
    top_d     = top_q;
    key_d     = key_q;
    ram_we    = 1'b0;
    ram_raddr = scan_q[ADDR_W-1:0];

    out_valid_d   = out_valid_q && out_stall_i;
    top_value_d   = top_value_q;
    top_valid_d   = top_valid_q;
    depth_now_d   = depth_now_q;
    is_empty_d    = is_empty_q;
    match_count_d = match_count_q;
    error_code_d  = error_code_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          match_d = '0;
          err_d   = ERR_NONE;
          state_d = S_OUT;
          unique case (operation_i)
            OP_PUSH: begin
              if (fill_q == CNT_W'(STACK_DEPTH)) begin
                err_d = ERR_OVERFLOW;
              end else begin
                ram_we = 1'b1;
                top_d  = in_data;
                fill_d = fill_q + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (fill_q == '0) begin
                err_d = ERR_UNDERFLOW;
              end else begin
                fill_d = fill_q - CNT_W'(1);
                // new top sits one below the old one
                if (fill_q != CNT_W'(1)) begin
                  ram_raddr = pop_ptr[ADDR_W-1:0];
                  state_d   = S_POP;
                end
              end
            end
            OP_COUNT: begin
              key_d = in_data;
              if (fill_q != '0) begin
                ram_raddr = '0;
                scan_d    = CNT_W'(1);
                state_d   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        top_d   = ram_rdata;
        state_d = S_OUT;
      end
      S_SCAN: begin
        if (ram_rdata == key_q) begin
          match_d = match_q + CNT_W'(1);
        end
        if (scan_q == fill_q) begin
          state_d = S_OUT;
        end else begin
          ram_raddr = scan_q[ADDR_W-1:0];
          scan_d    = scan_q + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          top_valid_d   = (fill_q != '0);
          top_value_d   = (fill_q != '0) ? VALUE_W'(top_q) : '0;
          depth_now_d   = LEVEL_W'(fill_q);
          is_empty_d    = (fill_q == '0);
          match_count_d = LEVEL_W'(match_q);
          error_code_d  = err_q;
          state_d       = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q        <= scan_d;
    match_q       <= match_d;
    err_q         <= err_d;
    top_q         <= top_d;
    key_q         <= key_d;
    top_value_q   <= top_value_d;
    top_valid_q   <= top_valid_d;
    depth_now_q   <= depth_now_d;
    is_empty_q    <= is_empty_d;
    match_count_q <= match_count_d;
    error_code_q  <= error_code_d;
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = top_value_q;
  assign top_valid_o   = top_valid_q;
  assign depth_now_o   = depth_now_q;
  assign is_empty_o    = is_empty_q;
  assign match_count_o = match_count_q;
  assign error_code_o  = error_code_q;

endmodule

// ===== sv/bswc_checker.sv =====
module bswc_checker
  import bswc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [VALUE_W-1:0] top_value_o,
  input logic               top_valid_o,
  input logic [LEVEL_W-1:0] depth_now_o,
  input logic               is_empty_o,
  input logic [LEVEL_W-1:0] match_count_o,
  input logic [ERR_W-1:0]   error_code_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(top_value_o)
      && $stable(depth_now_o) && $stable(error_code_o))
    else $error("result changed while stalled");

  a_empty_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (STACK_DEPTH < 64) |-> is_empty_o == (depth_now_o == '0))
    else $error("empty flag disagrees with depth");

  a_top_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_valid_o == !is_empty_o)
      && (top_valid_o || (top_value_o == '0)))
    else $error("top flags inconsistent");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o == ERR_UNDERFLOW) |-> is_empty_o
      && (match_count_o == '0))
    else $error("underflow on a non-empty stack");

endmodule

bind bounded_stack_with_count_core bswc_checker u_bswc_checker (.*);
